// ----- rtl/swhd_pkg.sv -----
// Shared types and constants for the sync word header deframer.
// Used by the top level, the serial divider and the port checker.
package swhd_pkg;

    localparam int SYM_W        = 8;
    localparam int SYNC_W       = 64;
    localparam int SYNC_LEN_W   = 7;
    localparam int BPS_W        = 4;
    localparam int HDR_BITS     = 64;
    localparam int HDR_CNT_W    = 7;
    localparam int BIT_IDX_W    = 3;
    localparam int LEN_W        = 16;
    localparam int QUO_W        = 19;
    localparam int DIV_STEPS    = QUO_W;
    localparam int DIV_CNT_W    = 5;
    localparam int OUT_W        = 72;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 64;

    localparam logic [SYNC_LEN_W-1:0] SYNC_LEN_RST = 7'd32;
    localparam logic [BPS_W-1:0]      BPS_RST      = 4'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LENGTH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_BPS     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAY_BPS     = 8'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_DIV,
        ST_LOAD
    } swhd_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } swhd_div_status_t;

endpackage

// ----- rtl/sync_word_header_deframer.sv -----
// Sync word correlator and header parser, one symbol bit per cycle.
// Each accepted symbol is unpacked bit by bit over its used bits (1 to 8), fewer after a match.
// A passing header then runs the serial divider and a load state before m_axis_tvalid.
// A new symbol is accepted only once the current one is unpacked; a passing header
// holds the input through division and load, and longer while the output register is still full.
// Reset (rst_n low, asynchronous) restores the register defaults and clears the control state.
module sync_word_header_deframer
    import swhd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SYM_W-1:0]       s_axis_tdata,   // [7:0] symbol_value
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] qindex, [15:8] qsize, [31:16] packet_counter,
    // [47:32] payload_bytes, [66:48] payload_symbols, [71:67] zero
    output logic [OUT_W-1:0]       m_axis_tdata
);

    swhd_state_t state_reg, state_next;

    logic [SYNC_W-1:0]      sync_word_reg;
    logic [SYNC_LEN_W-1:0]  sync_len_reg;
    logic [BPS_W-1:0]       hdr_bps_reg;
    logic [BPS_W-1:0]       pay_bps_reg;

    logic [SYNC_W-1:0]      search_reg, search_next;
    logic                   in_hdr_reg;
    logic [HDR_BITS-1:0]    hdr_reg, hdr_next;
    logic [HDR_CNT_W-1:0]   hcnt_reg, hcnt_next;
    logic [SYM_W-1:0]       sym_reg;
    logic [BIT_IDX_W-1:0]   bit_idx_reg;

    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_reg;

    logic [SYNC_W-1:0]      mask;
    logic [BIT_IDX_W-1:0]   first_idx;
    logic                   bit_now;
    logic                   match;
    logic                   last_bit;
    logic                   hdr_full;
    logic                   len_ok;
    logic                   div_start;
    logic                   out_load;
    logic [QUO_W-1:0]       quotient;
    swhd_div_status_t       div_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg <= '0;
            sync_len_reg  <= SYNC_LEN_RST;
            hdr_bps_reg   <= BPS_RST;
            pay_bps_reg   <= BPS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SYNC_WORD:   sync_word_reg <= cfg_data;
                CFG_SYNC_LENGTH: sync_len_reg  <= cfg_data[SYNC_LEN_W-1:0];
                CFG_HDR_BPS:     hdr_bps_reg   <= cfg_data[BPS_W-1:0];
                CFG_PAY_BPS:     pay_bps_reg   <= cfg_data[BPS_W-1:0];
                default:         ;
            endcase
        end
    end

    // Thermometer mask over the low sync_length bits; lengths of 64 and up cover all.
    always_comb
    begin
        for (int i = 0; i < SYNC_W; i++)
        begin
            mask[i] = (SYNC_LEN_W'(i) < sync_len_reg);
        end
    end

    // Index of the first (most significant) used bit, bits per symbol clamped to 1..8.
    always_comb
    begin
        if (hdr_bps_reg == '0)
        begin
            first_idx = '0;
        end
        else if (hdr_bps_reg > BPS_W'(SYM_W))
        begin
            first_idx = BIT_IDX_W'(SYM_W - 1);
        end
        else
        begin
            first_idx = BIT_IDX_W'(hdr_bps_reg - BPS_W'(1));
        end
    end

    always_comb
    begin
        bit_now     = sym_reg[bit_idx_reg];
        last_bit    = (bit_idx_reg == '0);
        search_next = {search_reg[SYNC_W-2:0], bit_now};
        match       = ~|((search_next ^ sync_word_reg) & mask);
        if (hcnt_reg < HDR_CNT_W'(HDR_BITS))
        begin
            hdr_next  = {hdr_reg[HDR_BITS-2:0], bit_now};
            hcnt_next = hcnt_reg + HDR_CNT_W'(1);
        end
        else
        begin
            hdr_next  = hdr_reg;
            hcnt_next = hcnt_reg;
        end
        hdr_full = (hcnt_next == HDR_CNT_W'(HDR_BITS));
        len_ok   = (hdr_next[47:32] == hdr_next[31:16]);
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_BITS;
                end
            end
            ST_BITS:
            begin
                if (!in_hdr_reg)
                begin
                    if (match || last_bit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (last_bit)
                begin
                    state_next = (hdr_full && len_ok) ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output and control decode.
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_BITS:
            begin
                div_start = in_hdr_reg && last_bit && hdr_full && len_ok;
            end
            ST_LOAD:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            search_reg    <= '0;
            in_hdr_reg    <= 1'b0;
            hdr_reg       <= '0;
            hcnt_reg      <= '0;
            bit_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && s_axis_tvalid)
            begin
                bit_idx_reg <= first_idx;
            end
            else if (state_reg == ST_BITS && !last_bit)
            begin
                bit_idx_reg <= bit_idx_reg - BIT_IDX_W'(1);
            end

            if (state_reg == ST_BITS)
            begin
                if (!in_hdr_reg)
                begin
                    search_reg <= search_next;
                    if (match)
                    begin
                        // The rest of this symbol is dropped; the header starts clean.
                        in_hdr_reg <= 1'b1;
                        hdr_reg    <= '0;
                        hcnt_reg   <= '0;
                    end
                end
                else if (last_bit && hdr_full)
                begin
                    hdr_reg    <= hdr_next;
                    in_hdr_reg <= 1'b0;
                    hcnt_reg   <= '0;
                end
                else
                begin
                    hdr_reg  <= hdr_next;
                    hcnt_reg <= hcnt_next;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            sym_reg <= s_axis_tdata;
        end
        if (out_load)
        begin
            out_reg <= {5'b0, quotient, hdr_reg[47:32], hdr_reg[15:0],
                        hdr_reg[55:48], hdr_reg[63:56]};
        end
    end

    swhd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({hdr_next[47:32], 3'b000}),
        .divisor  (pay_bps_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

// ----- rtl/swhd_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on swhd_pkg for widths and the status struct.
module swhd_div
    import swhd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [QUO_W-1:0]      dividend,
    input  logic [BPS_W-1:0]      divisor,
    output logic [QUO_W-1:0]      quotient,
    output swhd_div_status_t      status
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [QUO_W-1:0]      quo_reg, quo_next;
    logic [BPS_W-1:0]      rem_reg, rem_next;
    logic [BPS_W-1:0]      dvs_reg, dvs_next;
    logic [BPS_W:0]        trial;
    logic                  qbit;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        qbit      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            // A zero divisor is taken as one.
            dvs_next  = (divisor == '0) ? BPS_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[QUO_W-2:0], qbit};
            rem_next = qbit ? BPS_W'(trial - {1'b0, dvs_reg}) : trial[BPS_W-1:0];
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- rtl/swhd_checker.sv -----
// Port-level checker for the sync word header deframer, bound to the top level.
// Depends on swhd_pkg for port widths.
module swhd_checker
    import swhd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_W-1:0]       m_axis_tdata
);

    // A stalled result transaction keeps its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Symbols are unpacked serially, so the input closes right after a transaction.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transaction");

    // The symbol count never exceeds eight times the byte count, and padding stays zero.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[66:48] <= {m_axis_tdata[47:32], 3'b000})
                          && (m_axis_tdata[71:67] == 5'b0))
        else $error("payload symbol count out of range");

    // A result needs the serial division, so it never appears right after a symbol.
    a_no_fast_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

endmodule

bind sync_word_header_deframer swhd_checker u_swhd_checker (.*);
